// File: src/srt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_pkg
// Types and codes shared by the sorted record table and its channels.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int KEY_W    = 32;
  localparam int AGE_W    = 8;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_LOOKUP = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_DUMP   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [AGE_W-1:0] age;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_INS_HEAD,
    ST_FIND,
    ST_SHIFT,
    ST_DUMP
  } state_t;

endpackage
`default_nettype wire

// File: src/srt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_in_if / srt_out_if
// Request and result channels of the sorted record table.
// ----------------------------------------------------------------------------
interface srt_in_if;
  logic                                valid;
  logic                                ready;
  logic        [srt_pkg::KIND_W-1:0]   kind;
  logic signed [srt_pkg::KEY_W-1:0]    key;
  logic        [srt_pkg::AGE_W-1:0]    age;

  modport source (output valid, output kind, output key, output age, input ready);
  modport sink   (input valid, input kind, input key, input age, output ready);
endinterface

interface srt_out_if;
  logic                                valid;
  logic                                ready;
  logic        [srt_pkg::STATUS_W-1:0] status;
  logic signed [srt_pkg::KEY_W-1:0]    key_out;
  logic        [srt_pkg::AGE_W-1:0]    age_out;
  logic                                last;

  modport source (output valid, output status, output key_out, output age_out,
                  output last, input ready);
  modport sink   (input valid, input status, input key_out, input age_out,
                  input last, output ready);
endinterface
`default_nettype wire

// File: src/srt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/sorted_record_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_record_table
// Table of key/age records kept in ascending key order in one RAM.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          accepted when
//  in_ch     in   kind, key, age                   valid && ready
//  out_ch    out  status, key_out, age_out, last   valid && ready
//
// Records sit at RAM addresses 0 .. count-1; the read port is addressed by the
// next scan index, so read data always belongs to the current index.
// Insert walks back from the tail moving larger keys up, then writes the record
// (written at once into an empty table, refused by a full one); delete and
// lookup scan from the head, delete then moves later records down; dump sends
// the records in order. A new request is taken only when the scan is done and
// the result register is free. Reset empties the table; no RAM sweep needed.
// ----------------------------------------------------------------------------
module sorted_record_table #(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  srt_in_if.sink    in_ch,
  srt_out_if.source out_ch
);

  import srt_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic signed [KEY_W-1:0] key_r;
  logic [AGE_W-1:0]   age_r;
  logic               del_r;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r;
  logic signed [KEY_W-1:0] out_key_r;
  logic [AGE_W-1:0]   out_age_r;
  logic               out_last_r;

  logic               out_load;
  status_t            ld_status;
  logic signed [KEY_W-1:0] ld_key;
  logic [AGE_W-1:0]   ld_age;
  logic               ld_last;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  rec_t               wdata;
  rec_t               rdata;

  logic               slot_free;
  logic               accept;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   last_idx;
  logic               at_last;

  srt_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_nxt),
    .rdata (rdata)
  );

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cnt_m1      = cnt_r - CNT_W'(1);
  assign last_idx    = cnt_m1[IDX_W-1:0];
  assign at_last     = (idx_r == last_idx);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    we        = 1'b0;
    waddr     = idx_r;
    wdata     = rdata;
    out_load  = 1'b0;
    ld_status = STATUS_OK;
    ld_key    = '0;
    ld_age    = '0;
    ld_last   = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.kind)
            KIND_INSERT: begin
              out_load = 1'b1;
              ld_key   = in_ch.key;
              ld_age   = in_ch.age;
              if (cnt_r == CNT_W'(CAPACITY)) begin
                ld_status = STATUS_FULL;
              end else begin
                cnt_nxt = cnt_r + CNT_W'(1);
                if (cnt_r == '0) begin
                  we         = 1'b1;
                  waddr      = '0;
                  wdata.key  = in_ch.key;
                  wdata.age  = in_ch.age;
                end else begin
                  // Walk backward from the tail, moving larger keys up.
                  idx_nxt   = last_idx;
                  state_nxt = ST_INSERT;
                end
              end
            end
            KIND_DELETE, KIND_LOOKUP: begin
              if (cnt_r == '0) begin
                out_load  = 1'b1;
                ld_status = STATUS_NOT_FOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_FIND;
              end
            end
            KIND_CLEAR: begin
              cnt_nxt  = '0;
              out_load = 1'b1;
            end
            KIND_DUMP: begin
              if (cnt_r == '0) begin
                out_load  = 1'b1;
                ld_status = STATUS_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_INSERT: begin
        we    = 1'b1;
        waddr = idx_r + IDX_W'(1);
        if (rdata.key > key_r) begin
          wdata = rdata;
          if (idx_r == '0) begin
            state_nxt = ST_INS_HEAD;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end else begin
          wdata.key = key_r;
          wdata.age = age_r;
          state_nxt = ST_IDLE;
        end
      end

      ST_INS_HEAD: begin
        we        = 1'b1;
        waddr     = '0;
        wdata.key = key_r;
        wdata.age = age_r;
        state_nxt = ST_IDLE;
      end

      ST_FIND: begin
        // The result register is empty here: it was free when the request came.
        if (rdata.key == key_r) begin
          out_load = 1'b1;
          ld_key   = rdata.key;
          ld_age   = rdata.age;
          if (del_r && !at_last) begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_SHIFT;
          end else begin
            if (del_r) begin
              cnt_nxt = cnt_m1;
            end
            state_nxt = ST_IDLE;
          end
        end else if (at_last) begin
          out_load  = 1'b1;
          ld_status = STATUS_NOT_FOUND;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_SHIFT: begin
        we    = 1'b1;
        waddr = idx_r - IDX_W'(1);
        wdata = rdata;
        if (at_last) begin
          cnt_nxt   = cnt_m1;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_DUMP: begin
        // Holding the index keeps the read data steady while out_ch stalls.
        if (slot_free) begin
          out_load = 1'b1;
          ld_key   = rdata.key;
          ld_age   = rdata.age;
          ld_last  = at_last;
          if (at_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_ch.key;
      age_r <= in_ch.age;
      del_r <= (in_ch.kind == KIND_DELETE);
    end
    if (out_load) begin
      out_status_r <= ld_status;
      out_key_r    <= ld_key;
      out_age_r    <= ld_age;
      out_last_r   <= ld_last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.key_out = out_key_r;
  assign out_ch.age_out = out_age_r;
  assign out_ch.last    = out_last_r;

endmodule
`default_nettype wire

// File: tb/tb_sorted_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_record_table
// Self-checking bench for the sorted record table. Requests enter with random
// gaps when sender_idles is set, a shadow table predicts every result word, and
// each word that leaves the block is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_sorted_record_table;
  import srt_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int TAIL_CYCLES   = 4 * CAPACITY;
  localparam int PHASE_ITEMS   = 70;
  localparam int PHASE_COUNT   = 5;

  // Request codes that the block must ignore.
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  typedef struct {
    status_t                 status;
    logic signed [KEY_W-1:0] key;
    logic        [AGE_W-1:0] age;
    logic                    last;
  } result_t;

  logic clk;
  logic rst_n;

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  sorted_record_table #(.CAPACITY(CAPACITY)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rec_t                    shadow_recs [CAPACITY];
  int                      shadow_count = 0;
  result_t                 pending_results [$];
  int                      fail_count = 0;
  int                      cycle_count = 0;
  bit                      sender_idles = 1'b0;
  bit                      receiver_idles = 1'b0;
  logic signed [KEY_W-1:0] key_pool [8];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d words still expected", cycle_count,
             pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // Applies one accepted request to the shadow table and queues its results.
  function automatic void predict_table_op(logic [KIND_W-1:0] kind,
                                           logic signed [KEY_W-1:0] key,
                                           logic [AGE_W-1:0] age);
    int      pos;
    int      hit;
    int      i;
    result_t res;
    res = '{STATUS_OK, '0, '0, 1'b1};
    case (kind)
      KIND_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          // Equal keys go behind the ones already stored.
          pos = 0;
          while (pos < shadow_count && shadow_recs[pos].key <= key) pos++;
          for (i = shadow_count; i > pos; i--) shadow_recs[i] = shadow_recs[i - 1];
          shadow_recs[pos].key = key;
          shadow_recs[pos].age = age;
          shadow_count++;
        end
        res.key = key;
        res.age = age;
        pending_results.push_back(res);
      end
      KIND_DELETE, KIND_LOOKUP: begin
        hit = -1;
        for (i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_recs[i].key == key) hit = i;
        end
        if (hit < 0) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          res.key = shadow_recs[hit].key;
          res.age = shadow_recs[hit].age;
          if (kind == KIND_DELETE) begin
            for (i = hit; i + 1 < shadow_count; i++) shadow_recs[i] = shadow_recs[i + 1];
            shadow_count--;
          end
        end
        pending_results.push_back(res);
      end
      KIND_CLEAR: begin
        shadow_count = 0;
        pending_results.push_back(res);
      end
      KIND_DUMP: begin
        if (shadow_count == 0) begin
          res.status = STATUS_EMPTY;
          pending_results.push_back(res);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            res.key  = shadow_recs[i].key;
            res.age  = shadow_recs[i].age;
            res.last = (i + 1 == shadow_count);
            pending_results.push_back(res);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_request(logic [KIND_W-1:0] kind, logic signed [KEY_W-1:0] key,
                              logic [AGE_W-1:0] age);
    int gap;
    gap = sender_idles ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.key   <= key;
    in_ch.age   <= age;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_table_op(kind, key, age);
  endtask

  // Holds the request channel quiet until every predicted word has come out.
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void compare_field(string name, logic [KEY_W-1:0] want,
                                        logic [KEY_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected word, expected none, actual status %0d key %0h age %0h last %0b",
               $time, out_ch.status, out_ch.key_out, out_ch.age_out, out_ch.last);
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", KEY_W'(want.status), KEY_W'(out_ch.status));
    compare_field("key_out", want.key, out_ch.key_out);
    compare_field("age_out", KEY_W'(want.age), KEY_W'(out_ch.age_out));
    compare_field("last", KEY_W'(want.last), KEY_W'(out_ch.last));
  endfunction

  initial begin : result_checker
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = receiver_idles ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      check_result();
    end
  end

  // Mostly keys that collide, so duplicates, hits and misses all show up.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return key_pool[$urandom_range(0, 7)];
    if (r < 8 && shadow_count > 0) return shadow_recs[$urandom_range(0, shadow_count - 1)].key;
    return $urandom;
  endfunction

  task automatic test_empty_table();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    send_request(KIND_DUMP, '0, '0);
    send_request(KIND_LOOKUP, 32'sh7FFF_FFFF, '0);
    send_request(KIND_DELETE, -32'sd1, 8'hFF);
    send_request(KIND_UNUSED_LO, 32'sh8000_0000, 8'h55);
    wait_for_results();
  endtask

  task automatic test_fill_and_order();
    logic signed [KEY_W-1:0] fill_keys [CAPACITY] = '{
      32'sd5, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd5, 32'sh8000_0000,
      32'sd100, -32'sd100, 32'sd1, 32'sh4000_0000, -32'sd7, 32'sh7FFF_FFFF, 32'sd5,
      32'sd42, -32'sd2};
    sender_idles   = 1'b1;
    receiver_idles = 1'b0;
    for (int i = 0; i < CAPACITY; i++) send_request(KIND_INSERT, fill_keys[i], AGE_W'(i * 17));
    // The table is full now, so this record is dropped.
    send_request(KIND_INSERT, 32'sd3, 8'hAA);
    send_request(KIND_DUMP, '0, '0);
    send_request(KIND_LOOKUP, 32'sd5, '0);
    send_request(KIND_DELETE, 32'sh8000_0000, '0);
    send_request(KIND_CLEAR, '0, '0);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int                      insert_pct [PHASE_COUNT] = '{60, 45, 30, 55, 20};
    int                      sent;
    int                      roll;
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      sender_idles   = (p != 1 && p != 3);
      receiver_idles = (p != 1 && p != 2);
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7FFF_FFFF;
      key_pool[2] = '0;
      key_pool[3] = -32'sd1;
      for (int k = 4; k < 8; k++) key_pool[k] = (k < 6) ? $urandom_range(0, 20) : $urandom;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        key  = pick_key();
        roll = $urandom_range(0, 99);
        if (roll < insert_pct[p]) begin
          kind = KIND_INSERT;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 42) kind = KIND_DELETE;
          else if (roll < 80) kind = KIND_LOOKUP;
          else if (roll < 92) kind = KIND_DUMP;
          else if (roll < 95) kind = KIND_CLEAR;
          else kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end
        send_request(kind, key, AGE_W'($urandom_range(0, 255)));
        if (kind < KIND_UNUSED_LO) sent++;
      end
      wait_for_results();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_INSERT;
    in_ch.key   = '0;
    in_ch.age   = '0;
    rst_n       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_fill_and_order();
    test_random_traffic();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
